// ===== src/smx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;
	localparam int CELL_BITS_DEF = 32;
	localparam int DSTACK_DEPTH_DEF = 64;
	localparam int RSTACK_DEPTH_DEF = 64;
	localparam int DMEM_BYTES_DEF = 65536;

	typedef enum logic [4:0] {
		OP_NOOP = 5'd0, OP_EXIT = 5'd1, OP_LIT = 5'd2, OP_BRANCH = 5'd3,
		OP_ZBRANCH = 5'd4, OP_DROP = 5'd5, OP_PICK = 5'd6, OP_OVER = 5'd7,
		OP_SWAP = 5'd8, OP_TO_R = 5'd9, OP_R_FETCH = 5'd10, OP_R_FROM = 5'd11,
		OP_ADD = 5'd12, OP_SUB = 5'd13, OP_MUL = 5'd14, OP_DIV = 5'd15,
		OP_MOD = 5'd16, OP_TWO_SLASH = 5'd17, OP_RSHIFT = 5'd18, OP_LSHIFT = 5'd19,
		OP_LT = 5'd20, OP_EQ = 5'd21, OP_GT = 5'd22, OP_AND = 5'd23,
		OP_OR = 5'd24, OP_XOR = 5'd25, OP_INVERT = 5'd26, OP_FETCH = 5'd27,
		OP_STORE = 5'd28, OP_CFETCH = 5'd29, OP_CSTORE = 5'd30, OP_CALL = 5'd31
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_DUNDER = 3'd1, ST_DOVER = 3'd2, ST_RUNDER = 3'd3,
		ST_ROVER = 3'd4, ST_DIVZ = 3'd5, ST_HALTED = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_EXEC, S_DIV, S_MRD, S_MWR, S_WB, S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture item, start stack reads
		logic exec;      // evaluate and latch results
		logic div_start;
		logic mem_rd;    // read one byte
		logic mem_wr;    // write one byte
		logic wb;        // commit stack writes, depths, ip
		logic out_load;  // capture result item
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic need_mrd;
		logic need_mwr;
		logic div_done;
		logic mem_last;
	} sts_t;
endpackage
`default_nettype wire

// ===== src/stack_machine_execute_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake           | payload
// in      | in_valid/in_ready   | cmd, operand
// out     | out_valid/out_ready | top_value, data_depth_out, return_depth_out,
//         |                     | next_ip, halted_out, status
// A result is offered after its item passes the read, execute, write-back and output states
// and the result register; div and mod add the serial divider, fetch and store a step per byte.
// Reset: empty stacks, ip 0, halted. Stack and memory contents are not cleared.
// A new item is accepted only once the previous result is taken, or in the cycle it is
// taken; a held result stalls the input.
module stack_machine_execute_unit_core #(
	parameter int CELL_BITS = smx_pkg::CELL_BITS_DEF,
	parameter int DSTACK_DEPTH = smx_pkg::DSTACK_DEPTH_DEF,
	parameter int RSTACK_DEPTH = smx_pkg::RSTACK_DEPTH_DEF,
	parameter int DMEM_BYTES = smx_pkg::DMEM_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  cmd,
	input  wire logic [31:0] operand,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      top_value,
	output logic [6:0]       data_depth_out,
	output logic [6:0]       return_depth_out,
	output logic [15:0]      next_ip,
	output logic             halted_out,
	output logic [2:0]       status
);
	smx_pkg::ctl_t ctl;
	smx_pkg::sts_t sts;
	logic c_out_valid, ov_q, pend_q, res_free;
	logic [31:0] tv;
	logic [6:0] dd, rd;
	logic [15:0] ip;
	logic h;
	logic [2:0] st;

	// no start while a finished item is on its way to, or still held in, the result register
	assign res_free = !pend_q && (!ov_q || out_ready);

	smx_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_ready(in_ready), .out_valid(c_out_valid), .out_ready(res_free),
		.sts(sts), .ctl(ctl)
	);

	smx_datapath #(
		.CELL_BITS(CELL_BITS), .DSTACK_DEPTH(DSTACK_DEPTH),
		.RSTACK_DEPTH(RSTACK_DEPTH), .DMEM_BYTES(DMEM_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cmd(cmd), .operand(operand), .top_value(tv), .data_depth_out(dd),
		.return_depth_out(rd), .next_ip(ip), .halted_out(h), .status(st)
	);

	// result register: loaded the cycle after out_load, when datapath outputs are final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= c_out_valid;
			if (pend_q) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			top_value <= tv; data_depth_out <= dd; return_depth_out <= rd;
			next_ip <= ip; halted_out <= h; status <= st;
		end
	end

	assign out_valid = ov_q;
endmodule
`default_nettype wire

// ===== src/smx_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider on magnitudes, one quotient bit per cycle
module smx_div #(
	parameter int W = smx_pkg::CELL_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic [W-1:0]      quo,
	output logic [W-1:0]      rem
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W:0] trial;

	assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};

	// done follows the last step, when quo and rem are final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = q_q;
	assign rem = r_q;
endmodule
`default_nettype wire

// ===== src/smx_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smx_datapath #(
	parameter int CELL_BITS = smx_pkg::CELL_BITS_DEF,
	parameter int DSTACK_DEPTH = smx_pkg::DSTACK_DEPTH_DEF,
	parameter int RSTACK_DEPTH = smx_pkg::RSTACK_DEPTH_DEF,
	parameter int DMEM_BYTES = smx_pkg::DMEM_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire smx_pkg::ctl_t ctl,
	output smx_pkg::sts_t      sts,
	input  wire logic [4:0]    cmd,
	input  wire logic [31:0]   operand,
	output logic [31:0]        top_value,
	output logic [6:0]         data_depth_out,
	output logic [6:0]         return_depth_out,
	output logic [15:0]        next_ip,
	output logic               halted_out,
	output logic [2:0]         status
);
	localparam int CB = CELL_BITS / 8;
	localparam int DAW = $clog2(DSTACK_DEPTH);
	localparam int RAW = $clog2(RSTACK_DEPTH);
	localparam int DW = $clog2(DSTACK_DEPTH + 1);
	localparam int RW = $clog2(RSTACK_DEPTH + 1);
	localparam int MAW = $clog2(DMEM_BYTES);
	localparam int BW = $clog2(CB + 1);
	localparam logic [CELL_BITS-1:0] SIGN = {1'b1, {(CELL_BITS-1){1'b0}}};

	logic [CELL_BITS-1:0] dmem_a [DSTACK_DEPTH];
	logic [CELL_BITS-1:0] rmem [RSTACK_DEPTH];
	logic [7:0] dmem [DMEM_BYTES];

	logic [DW-1:0] dd_q;
	logic [RW-1:0] rd_q;
	logic [15:0] ip_q;
	logic halted_q;

	smx_pkg::op_t op_q;
	logic [31:0] opnd_q;
	logic [CELL_BITS-1:0] t0_q, t1_q, rt_q, pk_q, top_q;

	// captured results of exec
	logic [2:0] st_q;
	logic [15:0] nip_q;
	logic [DW-1:0] ndd_q;
	logic [RW-1:0] nrd_q;
	logic nhalt_q;
	logic dw_en_q, rw_en_q, dw2_en_q;
	logic [DAW-1:0] dw_a_q, dw2_a_q;
	logic [CELL_BITS-1:0] dw_v_q, dw2_v_q, rw_v_q;
	logic [RAW-1:0] rw_a_q;
	logic use_mem_q;

	// memory sequencing
	logic [MAW-1:0] ma_q;
	logic [BW-1:0] mb_q;
	logic [CELL_BITS-1:0] macc_q;
	logic mcell_q;
	logic [7:0] mbyte_q;
	logic [BW-1:0] msh_q;
	logic mrd_d1_q;
	logic [CELL_BITS-1:0] macc_full;

	logic [DW-1:0] dd_m1, dd_m2;
	logic [RW-1:0] rd_m1;
	assign dd_m1 = dd_q - 1'b1;
	assign dd_m2 = dd_q - DW'(2);
	assign rd_m1 = rd_q - 1'b1;

	// port A: top at load and after write-back, pick entry in between
	logic [DAW-1:0] ra;
	assign ra = (ctl.load || ctl.out_load) ? dd_m1[DAW-1:0] : DAW'(dd_m2 - DW'(t0_q));

	// stage 1: stack reads; the pick entry is read once the index is in t0_q, captured into pk_q
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q <= smx_pkg::op_t'(cmd);
			opnd_q <= operand;
			t0_q <= dmem_a[ra];
			t1_q <= dmem_a[dd_m2[DAW-1:0]];
			rt_q <= rmem[rd_m1[RAW-1:0]];
		end else if (!ctl.out_load) pk_q <= dmem_a[ra];
	end

	// divider
	logic [CELL_BITS-1:0] mag_n, mag_d, quo, rem;
	logic div_done;
	assign mag_n = t1_q[CELL_BITS-1] ? -t1_q : t1_q;
	assign mag_d = t0_q[CELL_BITS-1] ? -t0_q : t0_q;
	smx_div #(.W(CELL_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.num(mag_n), .den(mag_d), .done(div_done), .quo(quo), .rem(rem)
	);
	logic [CELL_BITS-1:0] div_res;
	always_comb begin
		if (op_q == smx_pkg::OP_DIV)
			div_res = (t1_q[CELL_BITS-1] ^ t0_q[CELL_BITS-1]) ? -quo : quo;
		else
			div_res = t1_q[CELL_BITS-1] ? -rem : rem;
	end

	// execute
	logic [15:0] next1, next2, tgt;
	logic [CELL_BITS-1:0] litv, alu, l, r;
	logic [2:0] st;
	logic [15:0] nip;
	logic [DW-1:0] ndd;
	logic [RW-1:0] nrd;
	logic nh, dwe, rwe, dwe2, ud, um;
	logic [DAW-1:0] dwa, dwa2;
	logic [CELL_BITS-1:0] dwv, dwv2, rwv;
	logic mul_sel;
	logic [CELL_BITS-1:0] mul_q;

	assign next1 = ip_q + 16'(CB);
	assign next2 = ip_q + 16'(2 * CB);
	assign tgt = opnd_q[15:0];
	assign litv = CELL_BITS'($signed(opnd_q));
	assign l = t1_q;
	assign r = t0_q;

	always_ff @(posedge clk) mul_q <= l * r;

	always_comb begin
		alu = '0;
		mul_sel = 1'b0;
		case (op_q)
			smx_pkg::OP_ADD: alu = l + r;
			smx_pkg::OP_SUB: alu = l - r;
			smx_pkg::OP_MUL: mul_sel = 1'b1;
			smx_pkg::OP_RSHIFT: alu = (r >= CELL_BITS'(CELL_BITS)) ? '0 : l >> r;
			smx_pkg::OP_LSHIFT: alu = (r >= CELL_BITS'(CELL_BITS)) ? '0 : l << r;
			smx_pkg::OP_LT: alu = ((l ^ SIGN) < (r ^ SIGN)) ? '1 : '0;
			smx_pkg::OP_EQ: alu = (l == r) ? '1 : '0;
			smx_pkg::OP_GT: alu = ((r ^ SIGN) < (l ^ SIGN)) ? '1 : '0;
			smx_pkg::OP_AND: alu = l & r;
			smx_pkg::OP_OR: alu = l | r;
			smx_pkg::OP_XOR: alu = l ^ r;
			default: alu = '0;
		endcase
		if (mul_sel) alu = mul_q;
	end

	always_comb begin
		st = smx_pkg::ST_OK;
		nip = next1;
		ndd = dd_q;
		nrd = rd_q;
		nh = halted_q;
		dwe = 1'b0; dwe2 = 1'b0; rwe = 1'b0; ud = 1'b0; um = 1'b0;
		dwa = dd_m1[DAW-1:0]; dwa2 = dd_m2[DAW-1:0];
		dwv = t0_q; dwv2 = t1_q; rwv = t0_q;
		if (halted_q && op_q != smx_pkg::OP_CALL) begin
			st = smx_pkg::ST_HALTED;
			nip = ip_q;
		end else begin
			case (op_q)
				smx_pkg::OP_CALL: begin
					nip = next2;
					if (halted_q) begin
						nh = 1'b0; nip = tgt;
					end else if (rd_q >= RW'(RSTACK_DEPTH)) st = smx_pkg::ST_ROVER;
					else begin
						rwe = 1'b1; rwv = CELL_BITS'(next2); nrd = rd_q + 1'b1; nip = tgt;
					end
				end
				smx_pkg::OP_EXIT: begin
					if (rd_q != '0) begin
						nrd = rd_m1; nip = rt_q[15:0];
					end else nh = 1'b1;
				end
				smx_pkg::OP_LIT: begin
					nip = next2;
					if (dd_q >= DW'(DSTACK_DEPTH)) st = smx_pkg::ST_DOVER;
					else begin
						dwe = 1'b1; dwa = dd_q[DAW-1:0]; dwv = litv; ndd = dd_q + 1'b1;
					end
				end
				smx_pkg::OP_BRANCH: nip = next1 + tgt;
				smx_pkg::OP_ZBRANCH: begin
					nip = next2;
					if (dd_q == '0) st = smx_pkg::ST_DUNDER;
					else begin
						ndd = dd_m1;
						if (t0_q == '0) nip = next1 + tgt;
					end
				end
				smx_pkg::OP_DROP: begin
					if (dd_q == '0) st = smx_pkg::ST_DUNDER;
					else ndd = dd_m1;
				end
				smx_pkg::OP_PICK: begin
					if (dd_q == '0) st = smx_pkg::ST_DUNDER;
					else if (t0_q >= CELL_BITS'(dd_m1)) st = smx_pkg::ST_DUNDER;
					else begin
						dwe = 1'b1; dwv = pk_q;
					end
				end
				smx_pkg::OP_OVER: begin
					if (dd_q < DW'(2)) st = smx_pkg::ST_DUNDER;
					else if (dd_q >= DW'(DSTACK_DEPTH)) st = smx_pkg::ST_DOVER;
					else begin
						dwe = 1'b1; dwa = dd_q[DAW-1:0]; dwv = t1_q; ndd = dd_q + 1'b1;
					end
				end
				smx_pkg::OP_SWAP: begin
					if (dd_q < DW'(2)) st = smx_pkg::ST_DUNDER;
					else begin
						dwe = 1'b1; dwv = t1_q; dwe2 = 1'b1; dwv2 = t0_q;
					end
				end
				smx_pkg::OP_TO_R: begin
					if (dd_q == '0) st = smx_pkg::ST_DUNDER;
					else if (rd_q >= RW'(RSTACK_DEPTH)) st = smx_pkg::ST_ROVER;
					else begin
						rwe = 1'b1; nrd = rd_q + 1'b1; ndd = dd_m1;
					end
				end
				smx_pkg::OP_R_FETCH, smx_pkg::OP_R_FROM: begin
					if (rd_q == '0) st = smx_pkg::ST_RUNDER;
					else if (dd_q >= DW'(DSTACK_DEPTH)) st = smx_pkg::ST_DOVER;
					else begin
						dwe = 1'b1; dwa = dd_q[DAW-1:0]; dwv = rt_q; ndd = dd_q + 1'b1;
						if (op_q == smx_pkg::OP_R_FROM) nrd = rd_m1;
					end
				end
				smx_pkg::OP_TWO_SLASH, smx_pkg::OP_INVERT,
				smx_pkg::OP_FETCH, smx_pkg::OP_CFETCH: begin
					if (dd_q == '0) st = smx_pkg::ST_DUNDER;
					else begin
						dwe = 1'b1;
						if (op_q == smx_pkg::OP_TWO_SLASH) dwv = {t0_q[CELL_BITS-1], t0_q[CELL_BITS-1:1]};
						else if (op_q == smx_pkg::OP_INVERT) dwv = ~t0_q;
						else um = 1'b1;
					end
				end
				smx_pkg::OP_STORE, smx_pkg::OP_CSTORE: begin
					if (dd_q < DW'(2)) st = smx_pkg::ST_DUNDER;
					else begin
						um = 1'b1; ndd = dd_m2;
					end
				end
				smx_pkg::OP_NOOP: ;
				default: begin
					if (dd_q < DW'(2)) st = smx_pkg::ST_DUNDER;
					else if ((op_q == smx_pkg::OP_DIV || op_q == smx_pkg::OP_MOD) && t0_q == '0)
						st = smx_pkg::ST_DIVZ;
					else begin
						dwe = 1'b1; dwa = dd_m2[DAW-1:0]; dwv = alu; ndd = dd_m1;
						ud = (op_q == smx_pkg::OP_DIV || op_q == smx_pkg::OP_MOD);
					end
				end
			endcase
		end
	end

	// last fetched byte is still in mbyte_q during write-back
	assign macc_full = mrd_d1_q ? (macc_q | (CELL_BITS'(mbyte_q) << (8 * msh_q))) : macc_q;

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			st_q <= st; nip_q <= nip; ndd_q <= ndd; nrd_q <= nrd; nhalt_q <= nh;
			dw_en_q <= dwe; dw_a_q <= dwa; dw_v_q <= dwv;
			dw2_en_q <= dwe2; dw2_a_q <= dwa2; dw2_v_q <= dwv2;
			rw_en_q <= rwe; rw_a_q <= rd_q[RAW-1:0]; rw_v_q <= rwv;
			use_mem_q <= um;
			mcell_q <= (op_q == smx_pkg::OP_FETCH || op_q == smx_pkg::OP_STORE);
			ma_q <= t0_q[MAW-1:0];
			mb_q <= '0;
			macc_q <= '0;
		end
		if (div_done) dw_v_q <= div_res;
		if (ctl.mem_rd) begin
			mbyte_q <= dmem[ma_q];
			msh_q <= mb_q;
			ma_q <= ma_q + 1'b1;
			mb_q <= mb_q + 1'b1;
		end
		if (mrd_d1_q) macc_q <= macc_full;
		if (ctl.mem_wr) begin
			dmem[ma_q] <= 8'(t1_q >> (8 * mb_q));
			ma_q <= ma_q + 1'b1;
			mb_q <= mb_q + 1'b1;
		end
		if (ctl.wb) begin
			if (dw_en_q) dmem_a[dw_a_q] <= (use_mem_q ? macc_full : dw_v_q);
			if (dw2_en_q) dmem_a[dw2_a_q] <= dw2_v_q;
			if (rw_en_q) rmem[rw_a_q] <= rw_v_q;
		end
		// top after commit: read in the cycle after write-back
		if (ctl.out_load) top_q <= dmem_a[ra];
	end

	assign sts.need_div = ud;
	assign sts.need_mrd = um && (op_q == smx_pkg::OP_FETCH || op_q == smx_pkg::OP_CFETCH);
	assign sts.need_mwr = um && (op_q == smx_pkg::OP_STORE || op_q == smx_pkg::OP_CSTORE);
	assign sts.div_done = div_done;
	assign sts.mem_last = mcell_q ? (mb_q == BW'(CB - 1)) : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dd_q <= '0; rd_q <= '0; ip_q <= '0; halted_q <= 1'b1;
			mrd_d1_q <= 1'b0;
		end else begin
			mrd_d1_q <= ctl.mem_rd;
			if (ctl.wb) begin
				dd_q <= ndd_q; rd_q <= nrd_q; ip_q <= nip_q; halted_q <= nhalt_q;
			end
		end
	end

	logic [CELL_BITS-1:0] topc;
	assign topc = (dd_q == '0) ? '0 : top_q;
	assign top_value = 32'($signed(topc));
	assign data_depth_out = 7'(dd_q);
	assign return_depth_out = 7'(rd_q);
	assign next_ip = ip_q;
	assign halted_out = halted_q;
	always_ff @(posedge clk) if (ctl.out_load) status <= st_q;
endmodule
`default_nettype wire

// ===== src/smx_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smx_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire smx_pkg::sts_t sts,
	output smx_pkg::ctl_t      ctl
);
	smx_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= smx_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			smx_pkg::S_IDLE: begin
				// out_ready: result register free for the next item
				in_ready = out_ready;
				if (in_valid && out_ready) begin
					ctl.load = 1'b1;
					state_d = smx_pkg::S_RD;
				end
			end
			smx_pkg::S_RD: state_d = smx_pkg::S_EXEC; // pick read and multiply settle
			smx_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.need_div) begin
					ctl.div_start = 1'b1;
					state_d = smx_pkg::S_DIV;
				end else if (sts.need_mrd) state_d = smx_pkg::S_MRD;
				else if (sts.need_mwr) state_d = smx_pkg::S_MWR;
				else state_d = smx_pkg::S_WB;
			end
			smx_pkg::S_DIV: if (sts.div_done) state_d = smx_pkg::S_WB;
			smx_pkg::S_MRD: begin
				ctl.mem_rd = 1'b1;
				if (sts.mem_last) state_d = smx_pkg::S_WB;
			end
			smx_pkg::S_MWR: begin
				ctl.mem_wr = 1'b1;
				if (sts.mem_last) state_d = smx_pkg::S_WB;
			end
			smx_pkg::S_WB: begin
				ctl.wb = 1'b1;
				state_d = smx_pkg::S_OUT;
			end
			smx_pkg::S_OUT: begin
				ctl.out_load = 1'b1;
				state_d = smx_pkg::S_IDLE;
				out_valid = 1'b1;
			end
			default: state_d = smx_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
